@@ hw/rtl/bocp_pkg.sv @@
// shared types and constants for the bgp open capability parser
package bocp_pkg;

    localparam logic [8:0] HEADER_BYTES = 9'd10;

    // header byte positions
    localparam logic [8:0] POS_ASN_HI    = 9'd1;
    localparam logic [8:0] POS_ASN_LO    = 9'd2;
    localparam logic [8:0] POS_HDR_FIRST = 9'd3;
    localparam logic [8:0] POS_HDR_LAST  = 9'd8;
    localparam logic [8:0] POS_PLEN      = 9'd9;

    localparam logic [7:0] PARAM_CAPS    = 8'd2;
    localparam logic [7:0] PARAM_MIN_LEN = 8'd2;
    localparam logic [7:0] CAP_MP        = 8'd1;
    localparam logic [7:0] CAP_ASN4      = 8'd65;
    localparam logic [7:0] CAP_ADDPATH   = 8'd69;
    localparam logic [7:0] CAP_FIXED_LEN = 8'd4;
    localparam logic [7:0] CAP_LAST_DATA = 8'd3;
    localparam logic [1:0] ENTRY_LAST    = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PARAMS,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_CAP     = 3'd1,
        KIND_ADDPATH = 3'd2,
        KIND_MP      = 3'd3,
        KIND_DONE    = 3'd4,
        KIND_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SHORT  = 2'd1,
        ERR_PARAMS = 2'd2,
        ERR_MP     = 2'd3
    } t_err;

    // one queue entry: all records caused by one input byte
    typedef struct packed {
        t_kind       a_kind;
        logic [7:0]  a_code;
        logic [15:0] a_afi;
        logic [7:0]  a_safi;
        logic [7:0]  a_sr;
        logic        a_dir;
        logic [8:0]  a_bytes;
        t_err        a_err;
        logic        has_b;
        t_kind       b_kind;
        logic [8:0]  b_bytes;
        t_err        b_err;
        logic [31:0] asn;
        logic [15:0] hold;
        logic [31:0] rid;
    } t_q_entry;

endpackage

@@ hw/rtl/bocp_in_if.sv @@
// input byte channel of the open message parser
interface bocp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sent_flag;

    modport source (output valid, data_byte, last_byte, sent_flag, input ready);
    modport sink   (input valid, data_byte, last_byte, sent_flag, output ready);
endinterface

@@ hw/rtl/bocp_out_if.sv @@
// result record channel of the open message parser
interface bocp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] asn_value;
    logic [15:0] hold_time;
    logic [31:0] router_id;
    logic [7:0]  cap_code;
    logic [15:0] afi;
    logic [7:0]  safi;
    logic [7:0]  send_receive;
    logic        direction;
    logic [8:0]  bytes_read;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (output valid, kind, asn_value, hold_time, router_id, cap_code, afi,
                    safi, send_receive, direction, bytes_read, error_code, last_result,
                    input ready);
    modport sink   (input valid, kind, asn_value, hold_time, router_id, cap_code, afi,
                    safi, send_receive, direction, bytes_read, error_code, last_result,
                    output ready);
endinterface

@@ hw/rtl/bgp_open_capability_parser.sv @@
// top level of the bgp open message capability parser
//
// i_in carries the OPEN body one byte per beat, starting at the version octet,
// with last_byte on the final byte of the buffer and sent_flag giving direction.
// o_out carries typed records: header, capability, add-path entry,
// multiprotocol entry, done and error; last_result marks the final record
// caused by one input byte. After an error record the records of that message
// are void.
// Throughput: one input byte per cycle while the queue is not full. A byte
// causes zero, one or two records; the output register sends one record per
// cycle while o_out.ready is high, so a byte with two records sends them in turn.
// A record passes from front tracking into the queue and then into the output
// register before it appears on o_out.
// A four-entry queue of per-byte record groups sits between the parser front
// and the output; when o_out is stalled the queue fills and i_in.ready drops
// only once it is full.
// Reset (i_rst_n low at a clock edge) returns the parser to the header phase
// and empties the queue and output register; last_byte does the same for the
// parser after its records are queued.
module bgp_open_capability_parser import bocp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bocp_in_if.sink    i_in,
    bocp_out_if.source o_out
);

    logic     push;
    logic     full;
    t_q_entry entry;
    logic     pop;
    logic     head_vld;
    t_q_entry head;

    bocp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    bocp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .o_full     (full),
        .i_pop      (pop),
        .o_head_vld (head_vld),
        .o_head     (head)
    );

    bocp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

@@ hw/rtl/bocp_front.sv @@
// front end: byte tracking, header, parameter and capability walk
module bocp_front import bocp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bocp_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output t_q_entry      o_entry
);

    t_phase      r_phase, n_phase;
    logic [8:0]  r_byte_count, n_byte_count;
    logic [47:0] r_hdr, n_hdr;
    logic [7:0]  r_ptotal, n_ptotal;
    logic [15:0] r_ptl, n_ptl;
    logic [7:0]  r_poff, n_poff;
    logic [15:0] r_ccl, n_ccl;
    logic [7:0]  r_coff, n_coff;
    logic [23:0] r_cb, n_cb;
    logic [31:0] r_asn, n_asn;
    logic        r_failed, n_failed;

    logic        acc;
    logic [8:0]  cnt_inc;
    logic        hdr_end;
    logic        rgn_end;
    logic [7:0]  b;
    logic        last;

    logic        x_vld;
    t_kind       x_kind;
    logic [7:0]  x_code;
    logic [15:0] x_afi;
    logic [7:0]  x_safi;
    logic [7:0]  x_sr;
    logic        x_dir;
    logic        x_ok;
    logic        t_vld;
    t_kind       t_kind_r;
    t_err        t_err_r;
    logic [8:0]  t_bytes;

    assign b       = i_in.data_byte;
    assign last    = i_in.last_byte;
    assign i_in.ready = !i_full;
    assign acc     = i_in.valid && !i_full;
    assign cnt_inc = r_byte_count + 9'd1;
    assign hdr_end = (cnt_inc == HEADER_BYTES);
    assign rgn_end = (cnt_inc == HEADER_BYTES + {1'b0, r_ptotal});

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEADER: begin
                if (hdr_end) begin
                    n_phase = (b == 8'd0) ? PH_DONE : PH_PARAMS;
                end
            end
            PH_PARAMS: begin
                if (rgn_end) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
        if (last) begin
            n_phase = PH_HEADER;
        end
    end

    // field tracking and record selection
    always_comb begin
        logic [31:0] cbw;
        logic [7:0]  d;
        logic [7:0]  code;

        n_byte_count = r_byte_count;
        n_hdr        = r_hdr;
        n_ptotal     = r_ptotal;
        n_ptl        = r_ptl;
        n_poff       = r_poff;
        n_ccl        = r_ccl;
        n_coff       = r_coff;
        n_cb         = r_cb;
        n_asn        = r_asn;
        n_failed     = r_failed;
        x_vld        = 1'b0;
        x_kind       = KIND_CAP;
        x_code       = '0;
        x_afi        = '0;
        x_safi       = '0;
        x_sr         = '0;
        x_dir        = 1'b0;
        t_vld        = 1'b0;
        t_kind_r     = KIND_DONE;
        t_err_r      = ERR_NONE;
        cbw          = {r_cb, b};
        d            = r_coff - 8'd2;
        code         = r_ccl[15:8];

        unique case (r_phase)
            PH_HEADER: begin
                n_byte_count = cnt_inc;
                if (r_byte_count == POS_ASN_HI) begin
                    n_asn = {16'h0000, b, 8'h00};
                end else if (r_byte_count == POS_ASN_LO) begin
                    n_asn = {r_asn[31:8], b};
                end else if (r_byte_count >= POS_HDR_FIRST && r_byte_count <= POS_HDR_LAST) begin
                    n_hdr = {r_hdr[39:0], b};
                end else if (r_byte_count == POS_PLEN) begin
                    n_ptotal = b;
                end
                if (hdr_end) begin
                    x_vld  = 1'b1;
                    x_kind = KIND_HEADER;
                    if (b == 8'd0) begin
                        t_vld = 1'b1;
                    end else if (last) begin
                        t_vld    = 1'b1;
                        t_kind_r = KIND_ERROR;
                        t_err_r  = ERR_PARAMS;
                    end
                end else if (last) begin
                    t_vld    = 1'b1;
                    t_kind_r = KIND_ERROR;
                    t_err_r  = ERR_SHORT;
                end
            end
            PH_PARAMS: begin
                n_byte_count = cnt_inc;
                if (r_poff == 8'd0) begin
                    n_ptl = {b, 8'h00};
                end else if (r_poff == 8'd1) begin
                    n_ptl  = {r_ptl[15:8], b};
                    n_coff = '0;
                end else if (r_ptl[15:8] == PARAM_CAPS && r_ptl[7:0] >= PARAM_MIN_LEN) begin
                    if (r_coff == 8'd0) begin
                        n_ccl = {b, 8'h00};
                        n_cb  = '0;
                    end else if (r_coff == 8'd1) begin
                        n_ccl = {r_ccl[15:8], b};
                        if (code == CAP_MP) begin
                            if (b != CAP_FIXED_LEN) begin
                                n_failed = 1'b1;
                            end
                        end else if (code != CAP_ASN4 && code != CAP_ADDPATH) begin
                            x_vld  = 1'b1;
                            x_kind = KIND_CAP;
                            x_code = code;
                        end
                    end else begin
                        n_cb = cbw[23:0];
                        if (code == CAP_ASN4 && r_ccl[7:0] == CAP_FIXED_LEN
                                && d == CAP_LAST_DATA) begin
                            n_asn  = cbw;
                            x_vld  = 1'b1;
                            x_kind = KIND_CAP;
                            x_code = code;
                        end else if (code == CAP_ADDPATH && d[1:0] == ENTRY_LAST) begin
                            x_vld  = 1'b1;
                            x_kind = KIND_ADDPATH;
                            x_code = code;
                            x_afi  = cbw[31:16];
                            x_safi = cbw[15:8];
                            x_sr   = b;
                            x_dir  = i_in.sent_flag;
                        end else if (code == CAP_MP && r_ccl[7:0] == CAP_FIXED_LEN
                                && d == CAP_LAST_DATA) begin
                            x_vld  = 1'b1;
                            x_kind = KIND_MP;
                            x_code = code;
                            x_afi  = cbw[31:16];
                            x_safi = b;
                        end
                    end
                    n_coff = r_coff + 8'd1;
                    if (r_coff != 8'd0
                            && ({1'b0, r_coff} + 9'd1) == ({1'b0, n_ccl[7:0]} + 9'd2)) begin
                        n_coff = '0;
                    end
                end
                n_poff = r_poff + 8'd1;
                if (r_poff != 8'd0
                        && ({1'b0, r_poff} + 9'd1) == ({1'b0, n_ptl[7:0]} + 9'd2)) begin
                    n_poff = '0;
                end
                if (rgn_end) begin
                    t_vld = 1'b1;
                    if (n_failed) begin
                        t_kind_r = KIND_ERROR;
                        t_err_r  = ERR_MP;
                    end
                end else if (last) begin
                    t_vld    = 1'b1;
                    t_kind_r = KIND_ERROR;
                    t_err_r  = ERR_PARAMS;
                end
            end
            PH_DONE: begin
                n_byte_count = r_byte_count;
            end
            default: begin
                n_byte_count = r_byte_count;
            end
        endcase

        // message boundary
        if (last) begin
            n_byte_count = '0;
            n_poff       = '0;
            n_coff       = '0;
            n_failed     = 1'b0;
        end
    end

    // records below done/error are dropped once a bad multiprotocol length is seen
    assign x_ok    = x_vld && !r_failed;
    assign t_bytes = (t_kind_r == KIND_DONE) ? cnt_inc : 9'd0;
    assign o_push  = acc && (x_ok || t_vld);

    always_comb begin
        o_entry.asn     = n_asn;
        o_entry.hold    = n_hdr[47:32];
        o_entry.rid     = n_hdr[31:0];
        o_entry.b_kind  = t_kind_r;
        o_entry.b_bytes = t_bytes;
        o_entry.b_err   = t_err_r;
        if (x_ok) begin
            o_entry.a_kind  = x_kind;
            o_entry.a_code  = x_code;
            o_entry.a_afi   = x_afi;
            o_entry.a_safi  = x_safi;
            o_entry.a_sr    = x_sr;
            o_entry.a_dir   = x_dir;
            o_entry.a_bytes = '0;
            o_entry.a_err   = ERR_NONE;
            o_entry.has_b   = t_vld;
        end else begin
            o_entry.a_kind  = t_kind_r;
            o_entry.a_code  = '0;
            o_entry.a_afi   = '0;
            o_entry.a_safi  = '0;
            o_entry.a_sr    = '0;
            o_entry.a_dir   = 1'b0;
            o_entry.a_bytes = t_bytes;
            o_entry.a_err   = t_err_r;
            o_entry.has_b   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_byte_count <= '0;
            r_poff       <= '0;
            r_coff       <= '0;
            r_failed     <= 1'b0;
        end else if (acc) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_poff       <= n_poff;
            r_coff       <= n_coff;
            r_failed     <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_hdr    <= n_hdr;
            r_ptotal <= n_ptotal;
            r_ptl    <= n_ptl;
            r_ccl    <= n_ccl;
            r_cb     <= n_cb;
            r_asn    <= n_asn;
        end
    end

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_byte_count < HEADER_BYTES))
        else $error("header phase past header length");

    a_hdr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> !r_failed)
        else $error("failed flag set in header phase");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> !o_push)
        else $error("record pushed after message end");

endmodule

@@ hw/rtl/bocp_queue.sv @@
// short queue of per-byte record groups between front and back
module bocp_queue import bocp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_head_vld,
    output t_q_entry o_head
);

    t_q_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;

    assign o_full     = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_head_vld))
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/bocp_back.sv @@
// back end: splits each queue entry into output beats
module bocp_back import bocp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_vld,
    input  t_q_entry  i_head,
    output logic      o_pop,
    bocp_out_if.source o_out
);

    logic        r_valid;
    logic        r_sel;
    t_kind       r_kind;
    logic [31:0] r_asn;
    logic [15:0] r_hold;
    logic [31:0] r_rid;
    logic [7:0]  r_code;
    logic [15:0] r_afi;
    logic [7:0]  r_safi;
    logic [7:0]  r_sr;
    logic        r_dir;
    logic [8:0]  r_bytes;
    t_err        r_err;
    logic        r_last;

    logic        load;
    t_kind       n_kind;
    logic [31:0] n_asn;
    logic [15:0] n_hold;
    logic [31:0] n_rid;
    logic [7:0]  n_code;
    logic [15:0] n_afi;
    logic [7:0]  n_safi;
    logic [7:0]  n_sr;
    logic        n_dir;
    logic [8:0]  n_bytes;
    t_err        n_err;
    logic        n_last;

    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && i_head_vld && (r_sel || !i_head.has_b);

    // second beat of an entry is always done or error
    always_comb begin
        if (r_sel) begin
            n_kind  = i_head.b_kind;
            n_code  = '0;
            n_afi   = '0;
            n_safi  = '0;
            n_sr    = '0;
            n_dir   = 1'b0;
            n_bytes = i_head.b_bytes;
            n_err   = i_head.b_err;
            n_last  = 1'b1;
        end else begin
            n_kind  = i_head.a_kind;
            n_code  = i_head.a_code;
            n_afi   = i_head.a_afi;
            n_safi  = i_head.a_safi;
            n_sr    = i_head.a_sr;
            n_dir   = i_head.a_dir;
            n_bytes = i_head.a_bytes;
            n_err   = i_head.a_err;
            n_last  = !i_head.has_b;
        end
        if (n_kind == KIND_ERROR) begin
            n_asn  = '0;
            n_hold = '0;
            n_rid  = '0;
        end else begin
            n_asn  = i_head.asn;
            n_hold = i_head.hold;
            n_rid  = i_head.rid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_vld;
            if (i_head_vld) begin
                r_sel <= !r_sel && i_head.has_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_vld) begin
            r_kind  <= n_kind;
            r_asn   <= n_asn;
            r_hold  <= n_hold;
            r_rid   <= n_rid;
            r_code  <= n_code;
            r_afi   <= n_afi;
            r_safi  <= n_safi;
            r_sr    <= n_sr;
            r_dir   <= n_dir;
            r_bytes <= n_bytes;
            r_err   <= n_err;
            r_last  <= n_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_kind;
    assign o_out.asn_value    = r_asn;
    assign o_out.hold_time    = r_hold;
    assign o_out.router_id    = r_rid;
    assign o_out.cap_code     = r_code;
    assign o_out.afi          = r_afi;
    assign o_out.safi         = r_safi;
    assign o_out.send_receive = r_sr;
    assign o_out.direction    = r_dir;
    assign o_out.bytes_read   = r_bytes;
    assign o_out.error_code   = r_err;
    assign o_out.last_result  = r_last;

    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_head_vld && i_head.has_b))
        else $error("second beat selected without a two-record entry");

endmodule

@@ tb/bocp_record_checker.sv @@
// record checker for the bgp open capability parser: predicts records per beat and compares
module bocp_record_checker import bocp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bocp_in_if   i_in_mon,
    bocp_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_records_due
);

    typedef struct packed {
        t_kind       kind;
        logic [31:0] asn;
        logic [15:0] hold;
        logic [31:0] rid;
        logic [7:0]  code;
        logic [15:0] afi;
        logic [7:0]  safi;
        logic [7:0]  mode;
        logic        dir;
        logic [8:0]  nbytes;
        t_err        err;
        logic        last_rec;
    } t_record;

    t_record pending_records[$];

    // parser state
    t_phase      phase;
    logic [8:0]  byte_cnt;
    logic [47:0] hold_rid;
    logic [7:0]  region_len;
    logic [7:0]  param_type;
    logic [7:0]  param_size;
    logic [8:0]  param_off;
    logic [7:0]  cap_code;
    logic [7:0]  cap_len;
    logic [8:0]  cap_off;
    logic [31:0] cap_data;
    logic [31:0] cur_asn;
    logic        mp_len_bad;

    int step_records;
    int records_seen = 0;
    int mismatches = 0;
    int records_open = 0;

    assign o_fail_count  = mismatches;
    assign o_records_due = records_open;

    function automatic void clear_parser();
        phase      = PH_HEADER;
        byte_cnt   = '0;
        hold_rid   = '0;
        region_len = '0;
        param_type = '0;
        param_size = '0;
        param_off  = '0;
        cap_code   = '0;
        cap_len    = '0;
        cap_off    = '0;
        cap_data   = '0;
        cur_asn    = '0;
        mp_len_bad = 1'b0;
    endfunction

    function automatic void push_record(t_kind k, logic [7:0] code, logic [15:0] afi,
                                        logic [7:0] safi, logic [7:0] mode, logic dir,
                                        logic [8:0] nbytes, t_err err);
        t_record r;
        // a bad multiprotocol length silences everything but done and error
        if (mp_len_bad && k < KIND_DONE)
            return;
        r.kind     = k;
        r.asn      = (k == KIND_ERROR) ? '0 : cur_asn;
        r.hold     = (k == KIND_ERROR) ? '0 : hold_rid[47:32];
        r.rid      = (k == KIND_ERROR) ? '0 : hold_rid[31:0];
        r.code     = code;
        r.afi      = afi;
        r.safi     = safi;
        r.mode     = mode;
        r.dir      = dir;
        r.nbytes   = nbytes;
        r.err      = err;
        r.last_rec = 1'b0;
        pending_records.insert(pending_records.size(), r);
        step_records++;
    endfunction

    function automatic void take_cap_byte(logic [7:0] b, logic sent);
        logic [8:0] d;
        if (cap_off == 9'd0) begin
            cap_code = b;
            cap_len  = '0;
            cap_data = '0;
        end else if (cap_off == 9'd1) begin
            cap_len = b;
            if (cap_code == CAP_MP) begin
                if (b != CAP_FIXED_LEN)
                    mp_len_bad = 1'b1;
            end else if (cap_code != CAP_ASN4 && cap_code != CAP_ADDPATH) begin
                push_record(KIND_CAP, cap_code, '0, '0, '0, 1'b0, '0, ERR_NONE);
            end
        end else begin
            d = cap_off - 9'd2;
            cap_data = {cap_data[23:0], b};
            if (cap_code == CAP_ASN4 && cap_len == CAP_FIXED_LEN && d == CAP_LAST_DATA) begin
                cur_asn = cap_data;
                push_record(KIND_CAP, cap_code, '0, '0, '0, 1'b0, '0, ERR_NONE);
            end else if (cap_code == CAP_ADDPATH && d[1:0] == ENTRY_LAST) begin
                push_record(KIND_ADDPATH, cap_code, cap_data[31:16], cap_data[15:8], b, sent,
                            '0, ERR_NONE);
            end else if (cap_code == CAP_MP && cap_len == CAP_FIXED_LEN
                         && d == CAP_LAST_DATA) begin
                push_record(KIND_MP, cap_code, cap_data[31:16], b, '0, 1'b0, '0, ERR_NONE);
            end
        end
        cap_off = cap_off + 9'd1;
        if (cap_off >= 9'd2 && cap_off == 9'd2 + cap_len)
            cap_off = '0;
    endfunction

    function automatic void take_param_byte(logic [7:0] b, logic sent);
        if (param_off == 9'd0) begin
            param_type = b;
            param_size = '0;
        end else if (param_off == 9'd1) begin
            param_size = b;
            cap_off    = '0;
        end else if (param_type == PARAM_CAPS && param_size >= PARAM_MIN_LEN) begin
            take_cap_byte(b, sent);
        end
        param_off = param_off + 9'd1;
        if (param_off >= 9'd2 && param_off == 9'd2 + param_size)
            param_off = '0;
    endfunction

    function automatic void predict_beat(logic [7:0] b, logic lst, logic sent);
        logic [8:0] pos;
        step_records = 0;
        // bytes past the region are ignored until the last beat
        if (phase == PH_DONE) begin
            if (lst)
                clear_parser();
            return;
        end
        pos = byte_cnt;
        byte_cnt = pos + 9'd1;
        if (phase == PH_HEADER) begin
            if (pos == POS_ASN_HI)
                cur_asn = {16'd0, b, 8'd0};
            else if (pos == POS_ASN_LO)
                cur_asn[7:0] = b;
            else if (pos >= POS_HDR_FIRST && pos <= POS_HDR_LAST)
                hold_rid = {hold_rid[39:0], b};
            else if (pos == POS_PLEN)
                region_len = b;
            if (byte_cnt == HEADER_BYTES) begin
                push_record(KIND_HEADER, '0, '0, '0, '0, 1'b0, '0, ERR_NONE);
                if (region_len == 8'd0) begin
                    push_record(KIND_DONE, '0, '0, '0, '0, 1'b0, byte_cnt, ERR_NONE);
                    phase = PH_DONE;
                end else begin
                    phase = PH_PARAMS;
                    if (lst)
                        push_record(KIND_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_PARAMS);
                end
            end else if (lst) begin
                push_record(KIND_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_SHORT);
            end
        end else begin
            take_param_byte(b, sent);
            if (byte_cnt == HEADER_BYTES + region_len) begin
                if (mp_len_bad)
                    push_record(KIND_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_MP);
                else
                    push_record(KIND_DONE, '0, '0, '0, '0, 1'b0, byte_cnt, ERR_NONE);
                phase = PH_DONE;
            end else if (lst) begin
                push_record(KIND_ERROR, '0, '0, '0, '0, 1'b0, '0, ERR_PARAMS);
            end
        end
        if (lst)
            clear_parser();
        if (step_records > 0)
            pending_records[pending_records.size() - 1].last_rec = 1'b1;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("%0t: record %0d: %s", $time, records_seen, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic compare_record();
        t_record want;
        records_seen++;
        if (pending_records.size() == 0) begin
            report($sformatf("record of kind %0d arrived with none expected", i_out_mon.kind));
            return;
        end
        want = pending_records.pop_front();
        check_field("kind", 32'(i_out_mon.kind), 32'(want.kind));
        check_field("asn_value", i_out_mon.asn_value, want.asn);
        check_field("hold_time", 32'(i_out_mon.hold_time), 32'(want.hold));
        check_field("router_id", i_out_mon.router_id, want.rid);
        check_field("cap_code", 32'(i_out_mon.cap_code), 32'(want.code));
        check_field("afi", 32'(i_out_mon.afi), 32'(want.afi));
        check_field("safi", 32'(i_out_mon.safi), 32'(want.safi));
        check_field("send_receive", 32'(i_out_mon.send_receive), 32'(want.mode));
        check_field("direction", 32'(i_out_mon.direction), 32'(want.dir));
        check_field("bytes_read", 32'(i_out_mon.bytes_read), 32'(want.nbytes));
        check_field("error_code", 32'(i_out_mon.error_code), 32'(want.err));
        check_field("last_result", 32'(i_out_mon.last_result), 32'(want.last_rec));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_records.delete();
        end else begin
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1)
                predict_beat(i_in_mon.data_byte, i_in_mon.last_byte, i_in_mon.sent_flag);
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1)
                compare_record();
        end
        records_open = pending_records.size();
    end

endmodule

@@ tb/bgp_open_capability_parser_tb.sv @@
// testbench top for the bgp open capability parser: message stimulus, receiver and verdict
module bgp_open_capability_parser_tb import bocp_pkg::*; ();

    localparam int ITEM_TARGET = 1800;
    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   records_due;
    int   hold_asks = 0;
    int   items_sent = 0;
    bit   no_gaps = 1'b0;

    // message under construction: caps -> one parameter body, region -> all parameters
    logic [7:0] caps[$];
    logic [7:0] region[$];
    logic [7:0] msg[$];

    bocp_in_if  in_bus();
    bocp_out_if out_bus();

    bgp_open_capability_parser dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    bocp_record_checker record_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_records_due(records_due)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.last_byte <= lst;
        in_bus.sent_flag <= 1'($urandom_range(0, 1));
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
    endtask

    // counted excludes bytes past the parameter region, which the block ignores
    task automatic send_message(input int counted);
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
        items_sent += counted;
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (records_due != 0);
    endtask

    task automatic add_cap(input logic [7:0] code, input int len);
        caps.insert(caps.size(), code);
        caps.insert(caps.size(), 8'(len));
        repeat (len)
            caps.insert(caps.size(), 8'($urandom));
    endtask

    task automatic wrap_param(input logic [7:0] ptype);
        region.insert(region.size(), ptype);
        region.insert(region.size(), 8'(caps.size()));
        foreach (caps[i])
            region.insert(region.size(), caps[i]);
        caps.delete();
    endtask

    task automatic start_message(input logic [7:0] version, input logic [15:0] asn16,
                                 input logic [15:0] hold, input logic [31:0] rid,
                                 input logic [7:0] plen);
        msg.delete();
        msg.insert(msg.size(), version);
        msg.insert(msg.size(), asn16[15:8]);
        msg.insert(msg.size(), asn16[7:0]);
        msg.insert(msg.size(), hold[15:8]);
        msg.insert(msg.size(), hold[7:0]);
        for (int i = 3; i >= 0; i--)
            msg.insert(msg.size(), rid[8*i +: 8]);
        msg.insert(msg.size(), plen);
        foreach (region[i])
            msg.insert(msg.size(), region[i]);
    endtask

    task automatic random_caps();
        int n;
        int pick;
        n = $urandom_range(1, 5);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                add_cap(CAP_MP, 4);
            else if (pick < 24)
                add_cap(CAP_MP, $urandom_range(0, 8));
            else if (pick < 40)
                add_cap(CAP_ASN4, 4);
            else if (pick < 44)
                add_cap(CAP_ASN4, $urandom_range(0, 7));
            else if (pick < 65)
                add_cap(CAP_ADDPATH, 4 * $urandom_range(0, 4)
                        + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
            else
                add_cap(8'($urandom), $urandom_range(0, 6));
        end
    endtask

    task automatic random_region();
        int np;
        region.delete();
        np = $urandom_range(0, 3);
        repeat (np) begin
            if ($urandom_range(0, 4) != 0) begin
                random_caps();
                wrap_param(PARAM_CAPS);
            end else begin
                repeat ($urandom_range(0, 6))
                    caps.insert(caps.size(), 8'($urandom));
                wrap_param(8'($urandom));
            end
        end
        while (region.size() > 255)
            void'(region.pop_back());
    endtask

    // receiver: random stalls, plus a long hold-off each time the sender asks for one
    initial begin : receiver
        int stall_left;
        int run_left;
        int holds_seen;
        stall_left = 0;
        run_left   = 0;
        holds_seen = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_asks) begin
                holds_seen = hold_asks;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(0, 6);
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : stimulus
        int msg_idx;
        int pick;
        int full;
        int keep;
        int counted;
        int waited;
        in_bus.valid     = 1'b0;
        in_bus.data_byte = '0;
        in_bus.last_byte = 1'b0;
        in_bus.sent_flag = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty parameter list with every header field at its maximum
        region.delete();
        start_message(8'hff, 16'hffff, 16'hffff, 32'hffff_ffff, 8'd0);
        send_message(msg.size());
        // all-zero header, then bytes past the region before the last beat
        start_message(8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 8'd0);
        msg.insert(msg.size(), 8'hff);
        msg.insert(msg.size(), 8'h00);
        send_message(10);
        // short header, and a message of one lone last beat
        start_message(8'd4, 16'h1234, 16'd30, 32'h0102_0304, 8'd3);
        repeat (5)
            void'(msg.pop_back());
        send_message(5);
        msg.delete();
        msg.insert(msg.size(), 8'h5a);
        send_message(1);
        // header completes on the last beat but parameters are announced
        start_message(8'd4, 16'd65000, 16'd180, 32'h0a00_0001, 8'd20);
        send_message(10);

        // every capability flavor, short and foreign parameters
        add_cap(CAP_MP, 4);
        add_cap(CAP_ASN4, 4);
        add_cap(CAP_ADDPATH, 10);
        add_cap(8'd0, 0);
        add_cap(8'd255, 1);
        add_cap(CAP_ASN4, 3);
        wrap_param(PARAM_CAPS);
        wrap_param(PARAM_CAPS);
        caps.insert(caps.size(), 8'hab);
        wrap_param(PARAM_CAPS);
        add_cap(CAP_MP, 4);
        wrap_param(8'd1);
        start_message(8'd4, 16'd23456, 16'd90, 32'hc0a8_0101, 8'(region.size()));
        send_message(msg.size());

        // bad multiprotocol length silences later records, error at region end
        region.delete();
        add_cap(CAP_MP, 5);
        add_cap(8'd2, 0);
        add_cap(CAP_ADDPATH, 4);
        wrap_param(PARAM_CAPS);
        start_message(8'd4, 16'd100, 16'd3, 32'h0b0b_0b0b, 8'(region.size()));
        send_message(msg.size());
        // same, cut one byte short: truncation wins over the length error
        void'(msg.pop_back());
        send_message(msg.size());

        // capability longer than its parameter, parameter longer than the region
        region.delete();
        add_cap(CAP_ADDPATH, 12);
        while (caps.size() > 7)
            void'(caps.pop_back());
        wrap_param(PARAM_CAPS);
        add_cap(8'd64, 2);
        wrap_param(PARAM_CAPS);
        start_message(8'd4, 16'd7, 16'd240, 32'h7f00_0001, 8'(region.size() - 3));
        send_message(msg.size() - 3);

        // largest region: one add-path capability filling 255 bytes
        region.delete();
        add_cap(CAP_ADDPATH, 251);
        wrap_param(PARAM_CAPS);
        start_message(8'd4, 16'($urandom), 16'($urandom), $urandom, 8'(region.size()));
        send_message(msg.size());

        msg_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            msg_idx++;
            if (msg_idx % 9 == 0)
                wait_drained();
            if (msg_idx == 4 || msg_idx == 25) begin
                // back-to-back beats with a record every two while the receiver holds off
                region.delete();
                repeat (50)
                    add_cap(8'($urandom_range(2, 60)), 0);
                wrap_param(PARAM_CAPS);
                start_message(8'd4, 16'($urandom), 16'($urandom), $urandom,
                              8'(region.size()));
                hold_asks <= hold_asks + 1;
                no_gaps = 1'b1;
                send_message(msg.size());
                continue;
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                msg.delete();
                repeat ($urandom_range(1, 30))
                    msg.insert(msg.size(), 8'($urandom));
                send_message(msg.size());
            end else begin
                random_region();
                start_message(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd4,
                              16'($urandom), 16'($urandom), $urandom, 8'(region.size()));
                full = msg.size();
                counted = full;
                if (pick < 22) begin
                    keep = $urandom_range(1, full - 1);
                    while (msg.size() > keep)
                        void'(msg.pop_back());
                    counted = keep;
                end else if (pick < 32 && region.size() > 0) begin
                    msg[9] = 8'($urandom_range(0, region.size() - 1));
                    counted = 10 + msg[9];
                end else if (pick < 40 && region.size() > 0) begin
                    msg[10 + $urandom_range(0, region.size() - 1)] = 8'($urandom);
                end
                if (pick >= 22 && $urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        msg.insert(msg.size(), 8'($urandom));
                send_message(counted);
            end
        end

        in_bus.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (records_due != 0 && waited < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && records_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
